>>> rtl/klum_pkg.sv
package klum_pkg;

  // store geometry default
  localparam int DEF_MAX_NODES = 1024;

  // field widths
  localparam int NODE_W      = 10;
  localparam int LABEL_W     = 11;
  localparam int COST_W      = 48;
  localparam int EDGE_COST_W = 32;
  localparam int FUNC_W      = 2;
  localparam int COUNT_W     = 11;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 56;

  // label codes and limits
  localparam logic [LABEL_W-1:0] UNASSIGNED     = 11'h7FF;
  localparam logic [LABEL_W-1:0] LABEL_TOP      = 11'd2046;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic [COST_W-1:0]  COST_MAX       = 48'hFFFF_FFFF_FFFF;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRESET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clear_regs;
    logic sweep_wr;
    logic preset_wr;
    logic rd_a;
    logic rd_b;
    logic cap_la;
    logic decide;
    logic wr_b;
    logic walk_rd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              edge_ok;
    logic              take;
    logic              both_un;
    logic              la_un;
    logic              lb_un;
    logic              sweep_last;
    logic              walk_empty;
    logic              walk_last;
    logic              out_free;
  } status_t;

endpackage

>>> rtl/klum_ram.sv
module klum_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/klum_ctrl.sv
module klum_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  klum_pkg::status_t status,
  output klum_pkg::cmd_t    cmd
);

  import klum_pkg::*;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_CLEAR    = 4'd3;
  localparam logic [3:0] ST_RD_A     = 4'd4;
  localparam logic [3:0] ST_RD_B     = 4'd5;
  localparam logic [3:0] ST_DECIDE   = 4'd6;
  localparam logic [3:0] ST_WR_B     = 4'd7;
  localparam logic [3:0] ST_WALK     = 4'd8;
  localparam logic [3:0] ST_WALK_END = 4'd9;
  localparam logic [3:0] ST_FINISH   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status.func)
          FUNC_CLEAR: begin
            cmd.clear_regs = 1'b1;
            state_next     = ST_CLEAR;
          end
          FUNC_PRESET: begin
            cmd.preset_wr = 1'b1;
            state_next    = ST_FINISH;
          end
          FUNC_EDGE: begin
            state_next = status.edge_ok ? ST_RD_A : ST_FINISH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b   = 1'b1;
        cmd.cap_la = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.take) begin
          state_next = ST_FINISH;
        end else if (status.both_un) begin
          state_next = ST_WR_B;
        end else if (status.la_un || status.lb_un) begin
          state_next = ST_FINISH;
        end else if (status.walk_empty) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WR_B: begin
        cmd.wr_b   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (status.walk_last) begin
          state_next = ST_WALK_END;
        end
      end
      ST_WALK_END: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/klum_dp.sv
module klum_dp #(
  parameter int MAX_NODES = klum_pkg::DEF_MAX_NODES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  klum_pkg::cmd_t                      cmd,
  output klum_pkg::status_t                   status,
  input  logic                                node_count_we,
  input  logic [klum_pkg::COUNT_W-1:0]        node_count_wdata,
  input  logic [klum_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [klum_pkg::FUNC_W-1:0]         s_tuser,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [klum_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  import klum_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  // held item
  logic [FUNC_W-1:0]      func_q;
  logic [NODE_W-1:0]      node_a;
  logic [NODE_W-1:0]      node_b;
  logic [NODE_W-1:0]      preset_label;
  logic [EDGE_COST_W-1:0] edge_cost;
  logic                   is_last;

  // run state and working registers
  logic [COUNT_W-1:0] node_count;
  logic [LABEL_W-1:0] next_label;
  logic [COST_W-1:0]  cost_sum;
  logic [LABEL_W-1:0] la;
  logic [LABEL_W-1:0] lb;
  logic               taken;
  logic [CW-1:0]      cnt;
  logic               pend;
  logic [AW-1:0]      pend_addr;

  // result register
  logic              out_valid;
  logic              out_taken;
  logic [COST_W-1:0] out_cost;
  logic              out_done;

  // label store ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [LABEL_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [LABEL_W-1:0] ram_rdata;

  logic               a_ok;
  logic               b_ok;
  logic               la_un;
  logic               lb_un;
  logic               take;
  logic [COST_W:0]    cost_add;
  logic [COST_W-1:0]  cost_new;
  logic [LW-1:0]      nc_ext;
  logic [LW-1:0]      max_ext;
  logic [LW-1:0]      lim;
  logic [LABEL_W-1:0] pl_next;

  klum_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (MAX_NODES)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // endpoint range and label compare, label of b comes straight off the store
  assign a_ok     = {22'd0, node_a} < 32'(MAX_NODES);
  assign b_ok     = {22'd0, node_b} < 32'(MAX_NODES);
  assign la_un    = (la == UNASSIGNED);
  assign lb_un    = (ram_rdata == UNASSIGNED);
  assign take     = la_un || (la != ram_rdata);

  // saturating cost sum
  assign cost_add = {1'b0, cost_sum} + {{(COST_W + 1 - EDGE_COST_W){1'b0}}, edge_cost};
  assign cost_new = cost_add[COST_W] ? COST_MAX : cost_add[COST_W-1:0];

  // relabel walk bound
  assign nc_ext  = LW'(node_count);
  assign max_ext = LW'(MAX_NODES);
  assign lim     = (nc_ext < max_ext) ? nc_ext : max_ext;

  assign pl_next = {1'b0, preset_label} + 11'd1;

  // status back to the controller
  always_comb begin
    status.func       = func_q;
    status.edge_ok    = a_ok && b_ok && (node_a != node_b);
    status.take       = take;
    status.both_un    = la_un && lb_un;
    status.la_un      = la_un;
    status.lb_un      = lb_un;
    status.sweep_last = (cnt == CW'(MAX_NODES - 1));
    status.walk_empty = (lim == '0);
    status.walk_last  = (LW'(cnt) == (lim - LW'(1)));
    status.out_free   = !out_valid || m_tready;
  end

  // store read address
  always_comb begin
    ram_raddr = cnt[AW-1:0];
    if (cmd.rd_a) begin
      ram_raddr = AW'(node_a);
    end else if (cmd.rd_b) begin
      ram_raddr = AW'(node_b);
    end
  end

  // store write: sweep, preset, edge update, or walk relabel
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = UNASSIGNED;
    if (cmd.sweep_wr) begin
      ram_we = 1'b1;
    end else if (cmd.preset_wr) begin
      ram_we    = a_ok;
      ram_waddr = AW'(node_a);
      ram_wdata = {1'b0, preset_label};
    end else if (cmd.decide && take) begin
      if (la_un && lb_un) begin
        ram_we    = 1'b1;
        ram_waddr = AW'(node_a);
        ram_wdata = next_label;
      end else if (la_un) begin
        ram_we    = 1'b1;
        ram_waddr = AW'(node_a);
        ram_wdata = ram_rdata;
      end else if (lb_un) begin
        ram_we    = 1'b1;
        ram_waddr = AW'(node_b);
        ram_wdata = la;
      end
    end else if (cmd.wr_b) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(node_b);
      ram_wdata = la;
    end else if (pend) begin
      ram_we    = (ram_rdata == lb);
      ram_waddr = pend_addr;
      ram_wdata = la;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      next_label <= '0;
      cost_sum   <= '0;
      cnt        <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (node_count_we) begin
        node_count <= node_count_wdata;
      end
      if (cmd.load_item) begin
        cnt <= '0;
      end else if (cmd.sweep_wr || cmd.walk_rd) begin
        cnt <= cnt + CW'(1);
      end
      pend <= cmd.walk_rd;
      if (cmd.clear_regs) begin
        next_label <= '0;
        cost_sum   <= '0;
      end
      if (cmd.preset_wr && a_ok && (pl_next > next_label)) begin
        next_label <= pl_next;
      end
      if (cmd.decide && take) begin
        cost_sum <= cost_new;
        if (la_un && lb_un && (next_label < LABEL_TOP)) begin
          next_label <= next_label + 11'd1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item fields, labels and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q       <= s_tuser;
      node_a       <= s_tdata[9:0];
      node_b       <= s_tdata[19:10];
      preset_label <= s_tdata[29:20];
      edge_cost    <= s_tdata[61:30];
      is_last      <= s_tlast;
      taken        <= 1'b0;
    end
    if (cmd.cap_la) begin
      la <= ram_rdata;
    end
    if (cmd.decide) begin
      lb <= ram_rdata;
      if (take) begin
        taken <= 1'b1;
        if (la_un && lb_un) begin
          la <= next_label;
        end
      end
    end
    pend_addr <= cnt[AW-1:0];
    if (cmd.out_load) begin
      out_taken <= taken;
      out_cost  <= cost_sum;
      out_done  <= (func_q == FUNC_EDGE) && is_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_cost, out_taken};
  assign m_tlast  = out_done;

endmodule

>>> rtl/kruskal_label_union_mst_core.sv
// channel      | signals                          | moves
// -------------+----------------------------------+-------------------------------------
// item in      | s_tvalid s_tready s_tdata s_tuser| one item: clear, preset or edge
//              | s_tlast                          |
// result out   | m_tvalid m_tready m_tdata m_tlast| edge_taken, tree_cost, run_done
// node_count   | node_count_we node_count_wdata   | register write, no read-back
//
// each item steps through the single read port and single write port of the label store; a
// merge walks min(node_count, MAX_NODES) label entries.
// after reset a clearing pass fills all MAX_NODES entries of the label store, with s_tready low.
// one item is in work at a time; a finished result waits in the output register while
// the next item is taken, and a stalled m_tready holds the item in its last step.
module kruskal_label_union_mst_core #(
  parameter int MAX_NODES = klum_pkg::DEF_MAX_NODES
) (
  input  logic                            clk,
  input  logic                            rst,
  // node_count register write
  input  logic                            node_count_we,
  input  logic [klum_pkg::COUNT_W-1:0]    node_count_wdata,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // node_a[9:0], node_b[19:10], preset_label[29:20], edge_cost[61:30], zero pad
  input  logic [klum_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[1:0]
  input  logic [klum_pkg::FUNC_W-1:0]     s_tuser,
  // is_last
  input  logic                            s_tlast,
  // results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // edge_taken[0], tree_cost[48:1], zero pad
  output logic [klum_pkg::OUT_DATA_W-1:0] m_tdata,
  // run_done
  output logic                            m_tlast
);

  import klum_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  klum_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // label store, sums and result register
  klum_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .node_count_we    (node_count_we),
    .node_count_wdata (node_count_wdata),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast)
  );

endmodule
